// ----- sv/sssc_pkg.sv -----
`default_nettype none
package sssc_pkg;

  // Card field widths
  localparam int SUIT_W = 8;
  localparam int VAL_W  = 4;

  // Default capacity of the card store
  localparam int DEF_MAX_CARDS = 32;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_GET_I,
    ST_RD_J,
    ST_GET_J,
    ST_PLACE,
    ST_SWAP_P,
    ST_RD_OUT,
    ST_GET_OUT,
    ST_SEND
  } sssc_state_e;

endpackage
`default_nettype wire

// ----- sv/sssc_store.sv -----
`default_nettype none
// Card store: one write port, one read port with registered read data.
module sssc_store
  import sssc_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_CARDS,
  parameter int DATA_W = SUIT_W + VAL_W + $clog2(DEF_MAX_CARDS)
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/selection_sort_with_stability_check.sv -----
`default_nettype none
// Card sorter. Cards (suit byte, value 0..15) stream in on s_axis one per cycle and are
// stored with their arrival index; up to MAX_CARDS cards are kept per set, and further
// cards are dropped and reported through the overflowed flag. The card sent with tlast
// high closes the set and starts a selection sort by value (first strict minimum wins,
// so equal values can change order). The sorted cards then leave on m_axis, tlast high
// on the final one; every card carries order_stable, which is 1 when all cards of equal
// value kept their arrival order, and overflowed. The sort runs through the single read
// port of the card store, one read per compare, and each sorted card is then read back,
// captured and held on m_axis until it is taken. s_axis_tready is low from the closing
// card until the last sorted card has been taken.
module selection_sort_with_stability_check
  import sssc_pkg::*;
#(
  parameter int MAX_CARDS = DEF_MAX_CARDS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // [7:0] card_suit, [11:8] card_value, [15:12] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,   // is_last
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] out_suit, [11:8] out_value, [12] order_stable, [13] overflowed, [15:14] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,   // end_of_run
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready
);

  localparam int AW = $clog2(MAX_CARDS);
  localparam int CW = $clog2(MAX_CARDS + 1);
  localparam int DW = SUIT_W + VAL_W + AW;
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CARDS);

  sssc_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          stable_q, stable_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [AW-1:0] pick_q, pick_d;
  logic [DW-1:0] cur_q, cur_d;
  logic [DW-1:0] min_q, min_d;
  logic [DW-1:0] prev_q, prev_d;
  logic [SUIT_W-1:0] out_suit_q, out_suit_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic              out_last_q, out_last_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic          in_acc;
  logic          out_acc;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;
  logic          i_more;
  logic          j_more;

  // Card fields: {order, value, suit}
  logic [VAL_W-1:0] rd_value, min_value, prev_value;
  logic [AW-1:0]    min_order, prev_order;

  assign rd_value   = mem_rdata[SUIT_W +: VAL_W];
  assign min_value  = min_q[SUIT_W +: VAL_W];
  assign prev_value = prev_q[SUIT_W +: VAL_W];
  assign min_order  = min_q[SUIT_W + VAL_W +: AW];
  assign prev_order = prev_q[SUIT_W + VAL_W +: AW];

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign i_inc   = i_q + ONE_C;
  assign j_inc   = j_q + ONE_C;
  assign i_more  = i_inc < count_q;
  assign j_more  = j_inc < count_q;

  sssc_store #(
    .DEPTH  (MAX_CARDS),
    .DATA_W (DW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && s_axis_tlast) state_d = ST_RD_I;
      end
      ST_RD_I:  state_d = ST_GET_I;
      ST_GET_I: state_d = i_more ? ST_RD_J : ST_PLACE;
      ST_RD_J:  state_d = ST_GET_J;
      ST_GET_J: state_d = j_more ? ST_RD_J : ST_PLACE;
      ST_PLACE: begin
        if (pick_q != i_q[AW-1:0]) state_d = ST_SWAP_P;
        else                       state_d = i_more ? ST_RD_I : ST_RD_OUT;
      end
      ST_SWAP_P:  state_d = i_more ? ST_RD_I : ST_RD_OUT;
      ST_RD_OUT:  state_d = ST_GET_OUT;
      ST_GET_OUT: state_d = ST_SEND;
      ST_SEND: begin
        if (m_axis_tready) state_d = out_last_q ? ST_LOAD : ST_RD_OUT;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Datapath control and handshake outputs
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    stable_d    = stable_q;
    i_d         = i_q;
    j_d         = j_q;
    pick_d      = pick_q;
    cur_d       = cur_q;
    min_d       = min_q;
    prev_d      = prev_q;
    out_suit_d  = out_suit_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          if (count_q < MAX_C) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[AW-1:0];
            mem_wdata = {count_q[AW-1:0], s_axis_tdata[SUIT_W +: VAL_W],
                         s_axis_tdata[SUIT_W-1:0]};
            count_d   = count_q + ONE_C;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            i_d      = '0;
            stable_d = 1'b1;
          end
        end
      end
      ST_RD_I: begin
        mem_raddr = i_q[AW-1:0];
      end
      ST_GET_I: begin
        cur_d  = mem_rdata;
        min_d  = mem_rdata;
        pick_d = i_q[AW-1:0];
        j_d    = i_inc;
      end
      ST_RD_J: begin
        mem_raddr = j_q[AW-1:0];
      end
      ST_GET_J: begin
        // strict less-than keeps the first minimum
        if (rd_value < min_value) begin
          min_d  = mem_rdata;
          pick_d = j_q[AW-1:0];
        end
        j_d = j_inc;
      end
      ST_PLACE: begin
        // minimum lands at position i; check order against the card placed before it
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
        mem_wdata = min_q;
        if ((i_q != '0) && (min_value == prev_value) && (min_order < prev_order)) begin
          stable_d = 1'b0;
        end
        prev_d = min_q;
        if (pick_q == i_q[AW-1:0]) begin
          i_d = i_more ? i_inc : '0;
        end
      end
      ST_SWAP_P: begin
        mem_we    = 1'b1;
        mem_waddr = pick_q;
        mem_wdata = cur_q;
        i_d       = i_more ? i_inc : '0;
      end
      ST_RD_OUT: begin
        mem_raddr = i_q[AW-1:0];
      end
      ST_GET_OUT: begin
        out_suit_d  = mem_rdata[SUIT_W-1:0];
        out_value_d = rd_value;
        out_last_d  = (i_inc == count_q);
      end
      ST_SEND: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            i_d = i_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      stable_q <= 1'b1;
      i_q      <= '0;
      j_q      <= '0;
      pick_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      stable_q <= stable_d;
      i_q      <= i_d;
      j_q      <= j_d;
      pick_q   <= pick_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    min_q       <= min_d;
    prev_q      <= prev_d;
    out_suit_q  <= out_suit_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tdata = {2'b00, ovf_q, stable_q, out_value_q, out_suit_q};
  assign m_axis_tlast = out_last_q;

  // Checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_C)
    else $error("card count beyond capacity");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (count_q == '0 && !ovf_q && s_axis_tready))
    else $error("set not cleared after last sorted card");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (count_q != '0 && i_q < count_q))
    else $error("emitting outside the stored set");

endmodule
`default_nettype wire

// ----- test/tb_selection_sort_with_stability_check.sv -----
`default_nettype none
module tb_selection_sort_with_stability_check;
  import sssc_pkg::*;

  localparam int CAPACITY    = DEF_MAX_CARDS;
  localparam int RANDOM_CARDS = 400;
  localparam int HOLD_AFTER  = 40;    // results taken before the long output stall
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT  = 12000; // well above the silent sort of a full 32-card set
  localparam int DRAIN_CYCLES = 40;

  // One stored card of the current set
  typedef struct {
    bit [SUIT_W-1:0] suit;
    bit [VAL_W-1:0]  value;
    int unsigned     order;
  } held_card_t;

  // One predicted output transaction
  typedef struct {
    bit [SUIT_W-1:0] suit;
    bit [VAL_W-1:0]  value;
    bit              stable;
    bit              dropped;
    bit              run_end;
  } sorted_card_t;

  // Tracks the card set in flight and the sorted cards still to come out
  class card_sort_board;
    held_card_t   held[CAPACITY];
    int unsigned  held_n;
    bit           dropped;
    sorted_card_t sorted_cards_q[$];
    int unsigned  errors;
    int unsigned  sets_closed;
    int unsigned  overflow_sets;
    int unsigned  unstable_sets;
    int unsigned  results_seen;

    function new();
      held_n  = 0;
      dropped = 0;
      errors  = 0;
    endfunction

    // Selection sort (first strict minimum, swap only if elsewhere), queue results
    function void close_set();
      held_card_t   work[CAPACITY];
      held_card_t   tmp;
      sorted_card_t res;
      int unsigned  pick;
      bit           stable;
      work = held;
      for (int unsigned i = 0; i < held_n; i++) begin
        pick = i;
        for (int unsigned j = i; j < held_n; j++) begin
          if (work[j].value < work[pick].value) pick = j;
        end
        if (pick != i) begin
          tmp        = work[i];
          work[i]    = work[pick];
          work[pick] = tmp;
        end
      end
      stable = 1'b1;
      for (int unsigned i = 1; i < held_n; i++) begin
        if (work[i].value == work[i-1].value && work[i].order < work[i-1].order)
          stable = 1'b0;
      end
      for (int unsigned k = 0; k < held_n; k++) begin
        res.suit    = work[k].suit;
        res.value   = work[k].value;
        res.stable  = stable;
        res.dropped = dropped;
        res.run_end = (k + 1 == held_n);
        sorted_cards_q = {sorted_cards_q, res};
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      if (!stable) unstable_sets++;
      held_n  = 0;
      dropped = 0;
    endfunction

    // Accepted input transaction
    function void note_card(bit [SUIT_W-1:0] suit, bit [VAL_W-1:0] value, bit last);
      if (held_n < CAPACITY) begin
        held[held_n].suit  = suit;
        held[held_n].value = value;
        held[held_n].order = held_n;
        held_n++;
      end else begin
        dropped = 1'b1;
      end
      if (last) close_set();
    endfunction

    // Accepted output transaction against the oldest prediction
    function void check_result(bit [OUT_TDATA_W-1:0] data, bit last);
      sorted_card_t want;
      results_seen++;
      if (sorted_cards_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual data %h last %b",
                 $time, data, last);
        errors++;
        return;
      end
      want = sorted_cards_q.pop_front();
      if (data[7:0] != want.suit) begin
        $display("%0t: out_suit mismatch, expected %h actual %h", $time, want.suit,
                 data[7:0]);
        errors++;
      end
      if (data[11:8] != want.value) begin
        $display("%0t: out_value mismatch, expected %0d actual %0d", $time, want.value,
                 data[11:8]);
        errors++;
      end
      if (data[12] != want.stable) begin
        $display("%0t: order_stable mismatch, expected %b actual %b", $time, want.stable,
                 data[12]);
        errors++;
      end
      if (data[13] != want.dropped) begin
        $display("%0t: overflowed mismatch, expected %b actual %b", $time, want.dropped,
                 data[13]);
        errors++;
      end
      if (last != want.run_end) begin
        $display("%0t: end_of_run mismatch, expected %b actual %b", $time, want.run_end,
                 last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return sorted_cards_q.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;

  card_sort_board board;
  bit             sender_burst;
  bit             receiver_burst;
  int unsigned    cards_sent;
  int unsigned    idle_cycles;

  selection_sort_with_stability_check u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // Clock
  always #4 clk_i = ~clk_i;

  // Send one card, after a random gap unless in a burst
  task automatic play_card(bit [SUIT_W-1:0] suit, bit [VAL_W-1:0] value, bit last);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - SUIT_W - VAL_W){1'b0}}, value, suit};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_card(suit, value, last);
    cards_sent++;
  endtask

  // Random set: mostly short, some exactly full, some overflowing
  task automatic play_random_set(int unsigned set_idx);
    int unsigned size;
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 19);
    if (set_idx == 3)      size = CAPACITY + 2;
    else if (set_idx == 7) size = CAPACITY;
    else if (roll == 0)    size = CAPACITY;
    else if (roll == 1)    size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
    else                   size = $urandom_range(1, 10);
    // narrow value range on some sets to force many ties
    top = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 15;
    sender_burst = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 0; k < size; k++)
      play_card(SUIT_W'($urandom_range(0, 255)), VAL_W'($urandom_range(0, top)),
                k == size - 1);
  endtask

  // Idle watchdog: no transaction on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, board.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Output side: random stalls, bursts, and one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 30 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      gap = receiver_burst ? 0 : $urandom_range(0, 6);
      if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata, m_axis_tlast);
      taken++;
    end
  end

  // Reset, directed sets, random sets, drain, verdict
  initial begin
    int unsigned set_idx;
    board         = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    sender_burst  = 1'b0;
    receiver_burst = 1'b0;
    cards_sent    = 0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-card sets at the field extremes
    play_card(8'hFF, 4'd15, 1'b1);
    play_card(8'h00, 4'd0, 1'b1);
    // tied pair pulled apart by a swap: order breaks
    play_card(8'h41, 4'd5, 1'b0);
    play_card(8'h42, 4'd5, 1'b0);
    play_card(8'h43, 4'd1, 1'b1);
    // swaps that keep the tied pair in order
    play_card(8'h01, 4'd15, 1'b0);
    play_card(8'h02, 4'd0, 1'b0);
    play_card(8'h03, 4'd7, 1'b0);
    play_card(8'h04, 4'd7, 1'b1);
    // identical cards stay distinct
    play_card(8'h55, 4'd4, 1'b0);
    play_card(8'h55, 4'd4, 1'b0);
    play_card(8'h55, 4'd4, 1'b0);
    play_card(8'hAA, 4'd2, 1'b1);
    // reverse-ordered set
    for (int k = 9; k >= 0; k--)
      play_card(SUIT_W'(8'h80 + k), VAL_W'(k), k == 0);

    // random sets
    cards_sent = 0;
    set_idx    = 0;
    while (cards_sent < RANDOM_CARDS) begin
      play_random_set(set_idx);
      set_idx++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sorted %0d card sets into %0d results: %0d with dropped cards, %0d reordered ties.",
             board.sets_closed, board.results_seen, board.overflow_sets, board.unstable_sets);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", board.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
sv/sssc_pkg.sv
sv/sssc_store.sv
sv/selection_sort_with_stability_check.sv
test/tb_selection_sort_with_stability_check.sv
